/* hw/rtl/rmm_pkg.sv */
// Shared types and constants for the row min/max window filter.
// Used by the top level and its checker; no dependencies.
`timescale 1ns / 1ps

package rmm_pkg;

    localparam int DATA_W     = 32;
    localparam int RADIUS_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic signed [DATA_W-1:0] t_height;

    localparam t_cfg_idx REG_RADIUS         = 2'd0;
    localparam t_cfg_idx REG_OPERATION      = 2'd1;
    localparam t_cfg_idx REG_INVALID_MARKER = 2'd2;

    localparam logic OP_ERODE  = 1'b0;
    localparam logic OP_DILATE = 1'b1;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd1;
    localparam t_height MARKER_RST   = 32'sh7FFF_FFFF;
    localparam t_height SENTINEL_MAX = 32'sh7FFF_FFFF;
    localparam t_height SENTINEL_MIN = 32'sh8000_0000;

endpackage

/* hw/rtl/rmm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/row_min_max_window_filter.sv */
// Row min/max window filter: 1-D erosion or dilation over one raster row.
// Each accepted item is written to the store; a result then passes S_SETUP,
// S_SCAN over window entries 0..end (end <= 2*radius), one entry per cycle
// through the single RAM read port and comparator, S_WAIT and S_EMIT. A row
// end flushes up to radius+1 results in turn; one item is handled at a time.
// Reset (synchronous, active low) clears control and counts; config takes reset values.
`timescale 1ns / 1ps

module row_min_max_window_filter #(
    parameter int MAX_RADIUS = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  rmm_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [rmm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [rmm_pkg::DATA_W-1:0]   i_in_height,
    input  logic                                i_in_row_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rmm_pkg::DATA_W-1:0]   o_filtered_height,
    output logic                                o_row_done
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [rmm_pkg::RADIUS_W-1:0] r_radius;
    logic                         r_op;
    rmm_pkg::t_height             r_marker;

    logic [IW-1:0] r_wp;
    logic [CW-1:0] r_seen;
    logic [CW-1:0] r_emit;
    logic          r_flush;
    logic [IW-1:0] r_offset;
    logic [IW-1:0] r_end;
    logic [IW-1:0] r_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    rmm_pkg::t_height r_acc;
    logic             r_centre_bad;

    logic             r_out_vld;
    rmm_pkg::t_height r_out_h;
    logic             r_out_done;

    logic [IW-1:0]    eff_radius;
    logic             accept_in;
    logic             out_free;
    logic [IW-1:0]    n_wp;
    logic [CW-1:0]    n_seen;
    logic             prior_ge_r;
    logic [IW-1:0]    prior_min_r;
    logic [CW-1:0]    limit;
    logic [CW-1:0]    left;
    logic [IW-1:0]    n_end;
    logic [IW:0]      addr_wrap;
    logic [IW-1:0]    raddr;
    rmm_pkg::t_height rd_data;
    rmm_pkg::t_height sentinel;
    rmm_pkg::t_height result;
    logic             better;
    logic             last_result;

    assign eff_radius = (32'(r_radius) > 32'(MAX_RADIUS)) ? IW'(MAX_RADIUS) : IW'(r_radius);

    assign accept_in = (r_state == S_IDLE) && i_in_valid;
    assign out_free  = !r_out_vld || i_out_ready;

    assign n_wp   = (r_wp == IW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_seen = (r_seen < CW'(DEPTH)) ? r_seen + 1'b1 : r_seen;

    assign prior_ge_r  = r_seen >= CW'(eff_radius);
    assign prior_min_r = prior_ge_r ? eff_radius : IW'(r_seen);

    // left clip = min(radius, emitted, samples held - 1 - offset)
    always_comb begin
        limit = r_seen - 1'b1 - CW'(r_offset);
        left  = CW'(eff_radius);
        if (r_emit < left) begin
            left = r_emit;
        end
        if (limit < left) begin
            left = limit;
        end
    end

    assign n_end = IW'(CW'(r_offset) + left);

    // entry of age r_idx in the circular store
    assign addr_wrap = (IW + 1)'(r_wp) + (IW + 1)'(DEPTH) - (IW + 1)'(r_idx);
    assign raddr     = (r_wp >= r_idx) ? (r_wp - r_idx) : IW'(addr_wrap);

    rmm_ram #(
        .WIDTH (rmm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept_in),
        .i_waddr (n_wp),
        .i_wdata (i_in_height),
        .i_re    (r_state == S_SCAN),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign sentinel = (r_op == rmm_pkg::OP_DILATE) ? rmm_pkg::SENTINEL_MIN
                                                   : rmm_pkg::SENTINEL_MAX;
    assign better   = (r_op == rmm_pkg::OP_DILATE) ? (rd_data > r_acc) : (rd_data < r_acc);

    assign result = (r_centre_bad || r_acc == sentinel) ? r_marker : r_acc;
    assign last_result = r_flush && (r_offset == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_radius  <= rmm_pkg::RADIUS_RST;
            r_op      <= rmm_pkg::OP_ERODE;
            r_marker  <= rmm_pkg::MARKER_RST;
            r_wp      <= '0;
            r_seen    <= '0;
            r_emit    <= '0;
            r_flush   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rmm_pkg::REG_RADIUS: begin
                        r_radius <= i_cfg_data[rmm_pkg::RADIUS_W-1:0];
                    end
                    rmm_pkg::REG_OPERATION: begin
                        r_op <= i_cfg_data[0];
                    end
                    rmm_pkg::REG_INVALID_MARKER: begin
                        r_marker <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == S_EMIT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            r_rd_vld <= (r_state == S_SCAN);

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_wp    <= n_wp;
                        r_seen  <= n_seen;
                        r_flush <= i_in_row_end;
                        if (i_in_row_end || prior_ge_r) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_idx == r_end) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (!r_flush || r_offset == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SETUP;
                        end
                        if (last_result) begin
                            r_seen <= '0;
                            r_emit <= '0;
                        end else if (r_emit < CW'(DEPTH)) begin
                            r_emit <= r_emit + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_offset <= i_in_row_end ? prior_min_r : eff_radius;
        end else if (r_state == S_EMIT && out_free && r_flush && r_offset != '0) begin
            r_offset <= r_offset - 1'b1;
        end

        if (r_state == S_SETUP) begin
            r_end        <= n_end;
            r_idx        <= '0;
            r_acc        <= sentinel;
            r_centre_bad <= 1'b0;
        end else begin
            if (r_state == S_SCAN && r_idx != r_end) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_rd_vld) begin
                if (rd_data != r_marker && better) begin
                    r_acc <= rd_data;
                end
                if (r_rd_idx == r_offset) begin
                    r_centre_bad <= (rd_data == r_marker);
                end
            end
        end

        r_rd_idx <= r_idx;

        if (r_state == S_EMIT && out_free) begin
            r_out_h    <= result;
            r_out_done <= last_result;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_vld;
    assign o_filtered_height = r_out_h;
    assign o_row_done        = r_out_done;

endmodule

/* hw/rtl/rmm_checker.sv */
// Port-level checker for the row min/max window filter, bound to the top level.
// Depends on rmm_pkg and row_min_max_window_filter.
`timescale 1ns / 1ps

module rmm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_in_row_end,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [rmm_pkg::DATA_W-1:0] o_filtered_height,
    input logic                              o_row_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_filtered_height) && $stable(o_row_done))
        else $error("result item changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    a_row_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_row_end |=> !o_in_ready)
        else $error("row end item did not start a flush");

endmodule

bind row_min_max_window_filter rmm_checker u_rmm_checker (.*);
